[src/pqre_pkg.sv]
`default_nettype none
package pqre_pkg;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} pix_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last_code;
	} code_t;

	typedef struct packed {
		logic [3:0] color;
		logic       last;
	} qent_t;

	localparam int unsigned NumColors = 16;
	localparam int unsigned NumChan   = 3;
	localparam int unsigned NumLevels = 4;
	localparam int unsigned SqW       = 16;
	localparam int unsigned DistW     = 18;

	// queue between classifier and encoder; depth must be a power of two
	localparam int unsigned QDepth = 8;
	localparam int unsigned QAW    = $clog2(QDepth);
	localparam int unsigned QCW    = $clog2(QDepth + 1);

	localparam logic [7:0] LEVEL [NumLevels] = '{8'h00, 8'h55, 8'haa, 8'hff};

	// palette entries as level codes per channel: r, g, b
	localparam logic [1:0] PAL_LVL [NumColors][NumChan] = '{
		'{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd2}, '{2'd0, 2'd2, 2'd0}, '{2'd0, 2'd2, 2'd2},
		'{2'd2, 2'd0, 2'd0}, '{2'd2, 2'd0, 2'd2}, '{2'd2, 2'd1, 2'd0}, '{2'd2, 2'd2, 2'd2},
		'{2'd1, 2'd1, 2'd1}, '{2'd1, 2'd1, 2'd3}, '{2'd1, 2'd3, 2'd1}, '{2'd1, 2'd3, 2'd3},
		'{2'd3, 2'd1, 2'd1}, '{2'd3, 2'd1, 2'd3}, '{2'd3, 2'd3, 2'd1}, '{2'd3, 2'd3, 2'd3}
	};

endpackage
`default_nettype wire

[src/pqre_classify.sv]
`default_nettype none
module pqre_classify (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pix_valid,
	input  wire pqre_pkg::pix_t pix,
	output logic                res_valid,
	output pqre_pkg::qent_t     res,
	output logic [2:0]          inflight
);
	import pqre_pkg::*;

	logic [7:0]     ch [NumChan];
	logic [7:0]     dif [NumChan][NumLevels];
	logic [SqW-1:0] sq_d [NumChan][NumLevels];

	logic           v_s1, v_s2, v_s3, v_s4;
	logic           last_s1, last_s2, last_s3, last_s4;
	logic [SqW-1:0] sq_s1 [NumChan][NumLevels];
	logic [DistW-1:0] dist_s2 [NumColors];
	logic [DistW-1:0] gdist_s3 [4];
	logic [3:0]     gidx_s3 [4];
	logic [3:0]     idx_s4;

	logic [DistW-1:0] gdist_d [4];
	logic [3:0]       gidx_d [4];
	logic [DistW-1:0] ha_d, hb_d;
	logic [3:0]       ia_d, ib_d, best_d;

	assign ch[0] = pix.red;
	assign ch[1] = pix.green;
	assign ch[2] = pix.blue;

	always_comb begin
		for (int c = 0; c < NumChan; c++) begin
			for (int l = 0; l < NumLevels; l++) begin
				dif[c][l]  = (ch[c] > LEVEL[l]) ? (ch[c] - LEVEL[l]) : (LEVEL[l] - ch[c]);
				sq_d[c][l] = SqW'(dif[c][l]) * SqW'(dif[c][l]);
			end
		end
	end

	// 16 -> 4, lower index wins ties
	always_comb begin
		for (int g = 0; g < 4; g++) begin
			logic [DistW-1:0] da, db;
			logic [3:0]       xa, xb;
			da = (dist_s2[4*g] <= dist_s2[4*g+1]) ? dist_s2[4*g] : dist_s2[4*g+1];
			xa = (dist_s2[4*g] <= dist_s2[4*g+1]) ? 4'(4*g) : 4'(4*g+1);
			db = (dist_s2[4*g+2] <= dist_s2[4*g+3]) ? dist_s2[4*g+2] : dist_s2[4*g+3];
			xb = (dist_s2[4*g+2] <= dist_s2[4*g+3]) ? 4'(4*g+2) : 4'(4*g+3);
			gdist_d[g] = (da <= db) ? da : db;
			gidx_d[g]  = (da <= db) ? xa : xb;
		end
	end

	// 4 -> 1
	always_comb begin
		ha_d   = (gdist_s3[0] <= gdist_s3[1]) ? gdist_s3[0] : gdist_s3[1];
		ia_d   = (gdist_s3[0] <= gdist_s3[1]) ? gidx_s3[0] : gidx_s3[1];
		hb_d   = (gdist_s3[2] <= gdist_s3[3]) ? gdist_s3[2] : gdist_s3[3];
		ib_d   = (gdist_s3[2] <= gdist_s3[3]) ? gidx_s3[2] : gidx_s3[3];
		best_d = (ha_d <= hb_d) ? ia_d : ib_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= pix_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sq_s1   <= sq_d;
		last_s1 <= pix.last_pixel;
		for (int i = 0; i < NumColors; i++) begin
			dist_s2[i] <= DistW'(sq_s1[0][PAL_LVL[i][0]]) + DistW'(sq_s1[1][PAL_LVL[i][1]])
				+ DistW'(sq_s1[2][PAL_LVL[i][2]]);
		end
		last_s2  <= last_s1;
		gdist_s3 <= gdist_d;
		gidx_s3  <= gidx_d;
		last_s3  <= last_s2;
		idx_s4   <= best_d;
		last_s4  <= last_s3;
	end

	assign res_valid = v_s4;
	assign res.color = idx_s4;
	assign res.last  = last_s4;
	assign inflight  = 3'(v_s1) + 3'(v_s2) + 3'(v_s3) + 3'(v_s4);

endmodule
`default_nettype wire

[src/pqre_queue.sv]
`default_nettype none
module pqre_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pqre_pkg::qent_t push_data,
	input  wire logic            pop,
	output logic                 head_valid,
	output pqre_pkg::qent_t      head,
	output logic [pqre_pkg::QCW-1:0] count
);
	import pqre_pkg::*;

	qent_t          ent_q [QDepth];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QAW'(1);
			if (pop)
				rd_q <= rd_q + QAW'(1);
			cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_data;
	end

	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_q];
	assign count      = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < QCW'(QDepth)))
		else $error("queue push while full");

endmodule
`default_nettype wire

[src/pqre_rle.sv]
`default_nettype none
module pqre_rle #(
	parameter int unsigned MAX_RUN = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire pqre_pkg::qent_t head,
	output logic                 pop,
	output logic                 enc_valid,
	input  wire logic            enc_stall,
	output pqre_pkg::code_t      enc
);
	import pqre_pkg::*;

	localparam logic [4:0] RunLast = 5'(MAX_RUN - 1);

	logic       active_q;
	logic [3:0] color_q;
	logic [3:0] cnt_q;

	code_t      obuf_q [4];
	logic [1:0] owr_q, ord_q;
	logic [2:0] ocnt_q;

	logic       take, emit1, emit2, out_pop;
	logic [3:0] ncnt;
	logic [1:0] npush;
	code_t      e1, e2;

	always_comb begin
		emit1 = active_q && (head.color != color_q);
		ncnt  = (emit1 || !active_q) ? 4'd0 : cnt_q + 4'd1;
		emit2 = ({1'b0, ncnt} >= RunLast) || head.last;
		e1.code      = {color_q, cnt_q};
		e1.last_code = 1'b0;
		e2.code      = {head.color, ncnt};
		e2.last_code = head.last;
	end

	// room for two codes before an item is taken
	assign take    = head_valid && (ocnt_q <= 3'd2);
	assign pop     = take;
	assign out_pop = (ocnt_q != 3'd0) && !enc_stall;
	assign npush   = take ? (2'(emit1) + 2'(emit2)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			color_q  <= '0;
			cnt_q    <= '0;
			owr_q    <= '0;
			ord_q    <= '0;
			ocnt_q   <= '0;
		end else begin
			if (take) begin
				color_q  <= head.color;
				active_q <= !emit2;
				cnt_q    <= emit2 ? 4'd0 : ncnt;
			end
			owr_q  <= owr_q + npush;
			if (out_pop)
				ord_q <= ord_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(npush) - 3'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (emit1) begin
				obuf_q[owr_q] <= e1;
				if (emit2)
					obuf_q[owr_q + 2'd1] <= e2;
			end else if (emit2) begin
				obuf_q[owr_q] <= e2;
			end
		end
	end

	assign enc_valid = (ocnt_q != 3'd0);
	assign enc       = obuf_q[ord_q];

	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 3'd4)
		else $error("code buffer overflow");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.last) |=> !active_q)
		else $error("run still pending after last pixel");

	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid |-> ({1'b0, enc.code[3:0]} < 5'(MAX_RUN)))
		else $error("run length exceeds maximum");

endmodule
`default_nettype wire

[src/palette_quantize_rle_encoder_top.sv]
// Maps each 24-bit RGB pixel to the nearest of 16 fixed palette colors
// (squared distance, lower index on ties) and run-length encodes the
// indices into bytes {color, run-1}, at most MAX_RUN pixels per byte.
// One pixel per cycle is taken sustained. A code is offered on enc once
// the pixel that closes it has passed 4 classifier stages, a queue write
// and a code buffer write.
// A pixel that closes a color run and also ends a full run or the image
// yields two codes; unless enc_stall holds them, those codes leave one per
// cycle from a 4-entry buffer, so the pixel rate falls below one per cycle
// only while such pixels and stalls on the code side fill it. pixel_stall
// rises when queue entries plus pixels in flight reach the queue depth.
`default_nettype none
module palette_quantize_rle_encoder_top #(
	parameter int unsigned MAX_RUN = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           pixel_valid,
	output logic                pixel_stall,
	input  wire pqre_pkg::pix_t pixel,
	output logic                enc_valid,
	input  wire logic           enc_stall,
	output pqre_pkg::code_t     enc
);
	import pqre_pkg::*;

	logic           res_valid;
	qent_t          res;
	logic [2:0]     inflight;
	logic           head_valid, pop;
	qent_t          head;
	logic [QCW-1:0] q_count;
	logic           pix_take;

	assign pixel_stall = (5'(q_count) + 5'(inflight)) >= 5'(QDepth);
	assign pix_take    = pixel_valid && !pixel_stall;

	pqre_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_take),
		.pix       (pixel),
		.res_valid (res_valid),
		.res       (res),
		.inflight  (inflight)
	);

	pqre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	pqre_rle #(
		.MAX_RUN (MAX_RUN)
	) u_rle (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.enc_valid  (enc_valid),
		.enc_stall  (enc_stall),
		.enc        (enc)
	);

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
	import pqre_pkg::*;

	localparam int RUN_MAX       = 16;
	localparam int RANDOM_PIXELS = 700;
	localparam int PAUSE_AT      = 350;
	localparam int HOLD_AT       = 20;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 24;
	localparam int NUM_ROWS      = 10;

	localparam logic [7:0] PALETTE [16][3] = '{
		'{8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'haa}, '{8'h00, 8'haa, 8'h00},
		'{8'h00, 8'haa, 8'haa}, '{8'haa, 8'h00, 8'h00}, '{8'haa, 8'h00, 8'haa},
		'{8'haa, 8'h55, 8'h00}, '{8'haa, 8'haa, 8'haa}, '{8'h55, 8'h55, 8'h55},
		'{8'h55, 8'h55, 8'hff}, '{8'h55, 8'hff, 8'h55}, '{8'h55, 8'hff, 8'hff},
		'{8'hff, 8'h55, 8'h55}, '{8'hff, 8'h55, 8'hff}, '{8'hff, 8'hff, 8'h55},
		'{8'hff, 8'hff, 8'hff}
	};

	// typed: the expected codes are given in the row, else the predictor decides
	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       lp;
		logic [4:0] rep;
		logic       typed;
		logic [1:0] n;
		code_t      e0;
		code_t      e1;
	} row_t;

	localparam row_t DIRECTED [NUM_ROWS] = '{
		'{8'h00, 8'h00, 8'h00, 1'b1, 5'd1, 1'b1, 2'd1, '{8'h00, 1'b1}, '{8'h00, 1'b0}},
		'{8'hff, 8'hff, 8'hff, 1'b1, 5'd1, 1'b1, 2'd1, '{8'hf0, 1'b1}, '{8'h00, 1'b0}},
		'{8'h00, 8'h00, 8'haa, 1'b1, 5'd1, 1'b1, 2'd1, '{8'h10, 1'b1}, '{8'h00, 1'b0}},
		'{8'hff, 8'h00, 8'h00, 1'b0, 5'd1, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		'{8'h00, 8'hff, 8'h00, 1'b0, 5'd1, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		'{8'h00, 8'h00, 8'hff, 1'b0, 5'd1, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		// tie between black and dark blue
		'{8'h00, 8'h00, 8'h55, 1'b0, 5'd1, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		// color change on the last pixel: two codes
		'{8'h55, 8'h55, 8'h55, 1'b1, 5'd1, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		'{8'hff, 8'hff, 8'hff, 1'b0, 5'd15, 1'b0, 2'd0, '{8'h00, 1'b0}, '{8'h00, 1'b0}},
		// full run ending on the last pixel
		'{8'hff, 8'hff, 8'hff, 1'b1, 5'd1, 1'b1, 2'd1, '{8'hff, 1'b1}, '{8'h00, 1'b0}}
	};

	logic  clk;
	logic  arst_n;
	logic  pixel_valid;
	logic  pixel_stall;
	pix_t  pixel;
	logic  enc_valid;
	logic  enc_stall;
	code_t enc;

	code_t pending_codes [$];
	int    errors      = 0;
	int    pixels_sent = 0;

	bit         run_on     = 1'b0;
	logic [3:0] run_color  = '0;
	logic [3:0] run_len_m1 = '0;

	palette_quantize_rle_encoder_top #(
		.MAX_RUN(RUN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel(pixel),
		.enc_valid(enc_valid),
		.enc_stall(enc_stall),
		.enc(enc)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [3:0] match_palette(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int best_dist;
		int sum_sq;
		int dr, dg, db;
		logic [3:0] best;
		best_dist = 1000000;
		best = '0;
		for (int i = 0; i < 16; i++) begin
			dr = int'(r) - int'(PALETTE[i][0]);
			dg = int'(g) - int'(PALETTE[i][1]);
			db = int'(b) - int'(PALETTE[i][2]);
			sum_sq = dr * dr + dg * dg + db * db;
			if (sum_sq < best_dist) begin
				best_dist = sum_sq;
				best = 4'(i);
			end
		end
		return best;
	endfunction

	task automatic encode_pixel(input pix_t p, output int n, output code_t c0, output code_t c1);
		logic [3:0] color;
		code_t c [2];
		color = match_palette(p.red, p.green, p.blue);
		n = 0;
		c[0] = '0;
		c[1] = '0;
		if (run_on && color != run_color) begin
			c[n].code = {run_color, run_len_m1};
			c[n].last_code = 1'b0;
			n++;
			run_color = color;
			run_len_m1 = '0;
		end else if (run_on) begin
			run_len_m1 = run_len_m1 + 4'd1;
		end else begin
			run_on = 1'b1;
			run_color = color;
			run_len_m1 = '0;
		end
		if (int'(run_len_m1) + 1 >= RUN_MAX || p.last_pixel) begin
			c[n].code = {run_color, run_len_m1};
			c[n].last_code = p.last_pixel;
			n++;
			run_on = 1'b0;
			run_len_m1 = '0;
		end
		c0 = c[0];
		c1 = c[1];
	endtask

	function automatic int draw_gap(input int idx);
		if (idx % 64 < 12)
			return 0;
		return int'($urandom_range(0, 10));
	endfunction

	function automatic logic [7:0] near_level(input logic [7:0] lvl);
		int v;
		v = int'(lvl) + int'($urandom_range(0, 40)) - 20;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	task automatic report_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic offer_pixel(input pix_t p, input int gap, input bit typed, input int n_typed,
			input code_t t0, input code_t t1);
		int n;
		code_t c0, c1;
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		encode_pixel(p, n, c0, c1);
		if (typed) begin
			n = n_typed;
			c0 = t0;
			c1 = t1;
		end
		if (n > 0)
			pending_codes.push_back(c0);
		if (n > 1)
			pending_codes.push_back(c1);
		pixels_sent++;
	endtask

	// code side: per-item stall, one long hold early on
	initial begin
		int gap;
		int taken;
		bit held;
		taken = 0;
		held = 1'b0;
		enc_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && taken >= HOLD_AT) begin
				gap = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				gap = draw_gap(taken);
			end
			if (gap > 0) begin
				enc_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			enc_stall <= 1'b0;
			@(posedge clk);
			while (!enc_valid) @(posedge clk);
			taken++;
		end
	end

	always @(posedge clk) begin
		code_t want;
		if (arst_n && enc_valid && !enc_stall) begin
			if (pending_codes.size() == 0) begin
				report_error($sformatf("unexpected code %h last %b", enc.code, enc.last_code));
			end else begin
				want = pending_codes.pop_front();
				if (enc.code !== want.code)
					report_error($sformatf("code: expected %h, got %h", want.code, enc.code));
				if (enc.last_code !== want.last_code)
					report_error($sformatf("last_code: expected %b, got %b (code %h)",
						want.last_code, enc.last_code, want.code));
			end
		end
	end

	initial begin
		pix_t p;
		int run_col;
		int run_left;
		int rand_count;
		bit noise;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		run_left = 0;
		run_col = 0;
		rand_count = 0;
		noise = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			for (int k = 0; k < int'(DIRECTED[i].rep); k++) begin
				p.red = DIRECTED[i].r;
				p.green = DIRECTED[i].g;
				p.blue = DIRECTED[i].b;
				p.last_pixel = DIRECTED[i].lp;
				offer_pixel(p, draw_gap(pixels_sent), DIRECTED[i].typed, int'(DIRECTED[i].n),
					DIRECTED[i].e0, DIRECTED[i].e1);
			end
		end

		// mostly runs of jittered palette colors, some raw noise
		while (rand_count < RANDOM_PIXELS) begin
			if (run_left == 0) begin
				noise = ($urandom_range(0, 9) < 3);
				run_col = int'($urandom_range(0, 15));
				run_left = noise ? 1 : int'($urandom_range(1, 24));
			end
			if (noise) begin
				p = pix_t'(25'($urandom));
				p.last_pixel = ($urandom_range(0, 19) == 0);
			end else begin
				p.red = near_level(PALETTE[run_col][0]);
				p.green = near_level(PALETTE[run_col][1]);
				p.blue = near_level(PALETTE[run_col][2]);
				p.last_pixel = ($urandom_range(0, 49) == 0);
			end
			run_left--;
			if (rand_count == PAUSE_AT) begin
				pixel_valid <= 1'b0;
				@(posedge clk);
				while (pending_codes.size() != 0) @(posedge clk);
			end
			offer_pixel(p, draw_gap(pixels_sent), 1'b0, 0, '0, '0);
			rand_count++;
		end
		pixel_valid <= 1'b0;

		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
